[src/cdq_pkg.sv]
`default_nettype none

package cdq_pkg;

    // Command codes
    localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [2:0] CMD_PUSH_REAR  = 3'd1;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [2:0] CMD_POP_REAR   = 3'd3;
    localparam logic [2:0] CMD_REPORT     = 3'd4;

    // Status codes
    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    // Word reported for an end of an empty deque
    localparam logic signed [31:0] EMPTY_WORD = -32'sd1;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] front_value;
        logic signed [31:0] rear_value;
        logic               is_empty;
        logic               is_full;
        logic [3:0]         fill_count;
    } out_item_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_READ
    } state_t;

endpackage

`default_nettype wire

[src/circular_deque.sv]
// Channel  Signals                          Payload
// -------  -------------------------------  ---------------------------------
// input    in_valid / in_ready / in_data    cmd, value
// output   out_valid / out_ready / out_data status, front/rear word, flags, count
//
// Push, no-op, rejected commands and pops that leave at most one entry load
// the result on acceptance; other pops first read the new end word in ST_READ.
// In ST_IDLE, items are taken while the result register is empty or draining.
// Reset (rst_n, async low) empties the deque; the RAM itself is not cleared.
`default_nettype none

module circular_deque import cdq_pkg::*; #(
    parameter int DEPTH = 8
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_item_t  in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_data
);

    localparam int AW = $clog2(DEPTH);

    logic          out_valid_reg;
    out_item_t     out_data_reg;
    logic          out_free;
    logic          res_load;
    out_item_t     res_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [31:0]   rd_data;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    cdq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_free (out_free),
        .res_load (res_load),
        .res_data (res_data),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data)
    );

    cdq_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Hold the result until the consumer takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_data_reg <= res_data;
        end
    end

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !res_load)
        else $error("result overwritten before it was taken");

    a_one_result_per_item: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> out_free)
        else $error("result loaded into a busy slot");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

[src/cdq_ram.sv]
`default_nettype none

module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[src/cdq_ctrl.sv]
`default_nettype none

module cdq_ctrl import cdq_pkg::*; #(
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire in_item_t                 in_data,
    input  wire logic                     out_free,
    output logic                          res_load,
    output out_item_t                     res_data,
    output logic                          wr_en,
    output logic [$clog2(DEPTH)-1:0]      wr_addr,
    output logic [31:0]                   wr_data,
    output logic                          rd_en,
    output logic [$clog2(DEPTH)-1:0]      rd_addr,
    input  wire logic [31:0]              rd_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    state_t             state_reg, state_next;
    logic [AW-1:0]      head_reg, head_next;
    logic [AW-1:0]      tail_reg, tail_next;
    logic [CW-1:0]      count_reg, count_next;
    logic signed [31:0] front_reg, front_next;
    logic signed [31:0] rear_reg, rear_next;
    logic               fetch_front_reg, fetch_front_next;

    logic               accept;
    logic               empty_now;
    logic               full_now;
    logic [AW-1:0]      head_inc, head_dec, tail_inc, tail_dec;
    logic [1:0]         status;

    assign empty_now = (count_reg == '0);
    assign full_now  = (count_reg == FULL_CNT);
    assign head_inc  = (head_reg == LAST_IDX) ? '0 : head_reg + AW'(1);
    assign head_dec  = (head_reg == '0) ? LAST_IDX : head_reg - AW'(1);
    assign tail_inc  = (tail_reg == LAST_IDX) ? '0 : tail_reg + AW'(1);
    assign tail_dec  = (tail_reg == '0) ? LAST_IDX : tail_reg - AW'(1);

    // Hold state and end-word caches
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            head_reg        <= '0;
            tail_reg        <= '0;
            count_reg       <= '0;
            fetch_front_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            count_reg       <= count_next;
            fetch_front_reg <= fetch_front_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_reg <= front_next;
        rear_reg  <= rear_next;
    end

    // Decode command, update indices, drive memory
    always_comb
    begin
        state_next       = state_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        count_next       = count_reg;
        front_next       = front_reg;
        rear_next        = rear_reg;
        fetch_front_next = fetch_front_reg;
        status           = STAT_DONE;
        wr_en            = 1'b0;
        wr_addr          = '0;
        wr_data          = in_data.value;
        rd_en            = 1'b0;
        rd_addr          = '0;
        res_load         = 1'b0;
        in_ready         = 1'b0;
        accept           = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = out_free;
                accept   = in_valid && out_free;
                if (accept)
                begin
                    res_load = 1'b1;
                    case (in_data.cmd)
                        CMD_PUSH_FRONT, CMD_PUSH_REAR:
                        begin
                            if (full_now)
                            begin
                                status = STAT_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CW'(1);
                                if (empty_now)
                                begin
                                    head_next  = '0;
                                    tail_next  = '0;
                                    wr_addr    = '0;
                                    front_next = in_data.value;
                                    rear_next  = in_data.value;
                                end
                                else if (in_data.cmd == CMD_PUSH_FRONT)
                                begin
                                    head_next  = head_dec;
                                    wr_addr    = head_dec;
                                    front_next = in_data.value;
                                end
                                else
                                begin
                                    tail_next = tail_inc;
                                    wr_addr   = tail_inc;
                                    rear_next = in_data.value;
                                end
                            end
                        end
                        CMD_POP_FRONT, CMD_POP_REAR:
                        begin
                            if (empty_now)
                            begin
                                status = STAT_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                                if (count_reg == CW'(1))
                                begin
                                    head_next = '0;
                                    tail_next = '0;
                                end
                                else if (in_data.cmd == CMD_POP_FRONT)
                                begin
                                    head_next = head_inc;
                                    if (count_reg == CW'(2))
                                    begin
                                        front_next = rear_reg;
                                    end
                                    else
                                    begin
                                        // Fetch the new front word
                                        rd_en            = 1'b1;
                                        rd_addr          = head_inc;
                                        fetch_front_next = 1'b1;
                                        res_load         = 1'b0;
                                        state_next       = ST_READ;
                                    end
                                end
                                else
                                begin
                                    tail_next = tail_dec;
                                    if (count_reg == CW'(2))
                                    begin
                                        rear_next = front_reg;
                                    end
                                    else
                                    begin
                                        // Fetch the new rear word
                                        rd_en            = 1'b1;
                                        rd_addr          = tail_dec;
                                        fetch_front_next = 1'b0;
                                        res_load         = 1'b0;
                                        state_next       = ST_READ;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            status = STAT_DONE;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                // Take the word from memory into the matching cache
                res_load = 1'b1;
                if (fetch_front_reg)
                begin
                    front_next = rd_data;
                end
                else
                begin
                    rear_next = rd_data;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Build the result from the updated state
        res_data.status      = status;
        res_data.is_empty    = (count_next == '0);
        res_data.is_full     = (count_next == FULL_CNT);
        res_data.fill_count  = 4'(count_next);
        res_data.front_value = (count_next == '0) ? EMPTY_WORD : front_next;
        res_data.rear_value  = (count_next == '0) ? EMPTY_WORD : rear_next;
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("entry count above depth");

    a_read_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |=> (state_reg == ST_IDLE))
        else $error("memory fetch took more than one cycle");

    a_empty_indices: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (head_reg == '0 && tail_reg == '0))
        else $error("indices not parked while empty");

    a_slot_free_on_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> out_free)
        else $error("result slot busy when fetched word arrives");
`endif

endmodule

`default_nettype wire

[test/circular_deque_checker.sv]
`default_nettype none

module circular_deque_checker import cdq_pkg::*; #(
    parameter int DEPTH = 8
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire logic      in_ready,
    input  wire in_item_t  in_data,
    input  wire logic      out_valid,
    input  wire logic      out_ready,
    input  wire out_item_t out_data,
    output int             mismatches,
    output int             outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the deque
    logic signed [31:0] ring_words [DEPTH];
    int unsigned        front_idx;
    int unsigned        rear_idx;
    int unsigned        held;

    // Results predicted for accepted items, oldest first
    out_item_t          pending_results [$];
    out_item_t          want;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("%0t ns: mismatch on %s: got %0h, predicted %0h", $time, what, got, exp_val);
        mismatches++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] exp_val);
        if (got !== exp_val)
            report_mismatch(what, got, exp_val);
    endtask

    // Apply one command to the shadow deque and return the report it causes
    function automatic out_item_t apply_command(input in_item_t item);
        out_item_t  res;
        logic [1:0] stat;
        stat = STAT_DONE;
        case (item.cmd)
            CMD_PUSH_FRONT, CMD_PUSH_REAR:
            begin
                if (held >= DEPTH)
                    stat = STAT_FULL;
                else
                begin
                    // first entry always lands in slot zero
                    if (held == 0)
                    begin
                        front_idx     = 0;
                        rear_idx      = 0;
                        ring_words[0] = item.value;
                    end
                    else if (item.cmd == CMD_PUSH_FRONT)
                    begin
                        front_idx = (front_idx == 0) ? DEPTH - 1 : front_idx - 1;
                        ring_words[front_idx] = item.value;
                    end
                    else
                    begin
                        rear_idx = (rear_idx + 1 >= DEPTH) ? 0 : rear_idx + 1;
                        ring_words[rear_idx] = item.value;
                    end
                    held++;
                end
            end
            CMD_POP_FRONT, CMD_POP_REAR:
            begin
                if (held == 0)
                    stat = STAT_EMPTY;
                else
                begin
                    // last pop parks both indices at zero
                    if (held == 1)
                    begin
                        front_idx = 0;
                        rear_idx  = 0;
                    end
                    else if (item.cmd == CMD_POP_FRONT)
                        front_idx = (front_idx + 1 >= DEPTH) ? 0 : front_idx + 1;
                    else
                        rear_idx = (rear_idx == 0) ? DEPTH - 1 : rear_idx - 1;
                    held--;
                end
            end
            default: ; // report and spare codes leave the deque alone
        endcase
        res.status      = stat;
        res.is_empty    = (held == 0);
        res.is_full     = (held >= DEPTH);
        res.fill_count  = 4'(held);
        res.front_value = (held == 0) ? EMPTY_WORD : ring_words[front_idx];
        res.rear_value  = (held == 0) ? EMPTY_WORD : ring_words[rear_idx];
        return res;
    endfunction

    // Predict on every accepted item, compare on every accepted result
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_idx = 0;
            rear_idx  = 0;
            held      = 0;
            pending_results.delete();
            outstanding = 0;
            mismatches  = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                pending_results.push_back(apply_command(in_data));
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("unexpected result, status", 32'(out_data.status), 32'hx);
                else
                begin
                    want = pending_results.pop_front();
                    check_field("status", 32'(out_data.status), 32'(want.status));
                    check_field("front_value", out_data.front_value, want.front_value);
                    check_field("rear_value", out_data.rear_value, want.rear_value);
                    check_field("is_empty", 32'(out_data.is_empty), 32'(want.is_empty));
                    check_field("is_full", 32'(out_data.is_full), 32'(want.is_full));
                    check_field("fill_count", 32'(out_data.fill_count),
                                32'(want.fill_count));
                end
            end
            outstanding = pending_results.size();
        end
    end

endmodule

`default_nettype wire

[test/circular_deque_tb.sv]
`default_nettype none

module circular_deque_tb import cdq_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          DEPTH       = 8;
    localparam int          RANDOM_CMDS = 1700;
    localparam logic [2:0]  CMD_LAST    = 3'd7;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    in_item_t  in_data   = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    out_item_t out_data;
    int        fail_count;
    int        pending;

    // sender stretches without idle cycles
    bit        tx_calm = 1'b0;

    // receiver stall bookkeeping
    int        stall_left = 0;
    int        calm_left  = 0;

    always #5 clk = ~clk;

    circular_deque #(.DEPTH(DEPTH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    circular_deque_checker #(.DEPTH(DEPTH)) chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .mismatches  (fail_count),
        .outstanding (pending)
    );

    // Mostly short idle stretches, now and then a long one
    function automatic int idle_length();
        return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    endfunction

    // Pick a command; lean selects push-heavy, pop-heavy or balanced traffic
    function automatic logic [2:0] pick_command(input int lean);
        int push_pct;
        if ($urandom_range(0, 99) < 6)
            return 3'($urandom_range(CMD_REPORT, CMD_LAST));
        push_pct = (lean == 0) ? 75 : (lean == 1) ? 25 : 50;
        if ($urandom_range(0, 99) < push_pct)
            return $urandom_range(0, 1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
        return $urandom_range(0, 1) ? CMD_POP_REAR : CMD_POP_FRONT;
    endfunction

    // Mostly random words, sometimes the corners
    function automatic logic signed [31:0] pick_word();
        case ($urandom_range(0, 39))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return EMPTY_WORD;
            3:       return '0;
            default: return $urandom;
        endcase
    endfunction

    // Offer one item and hold it until accepted; entered and left on a falling edge
    task automatic send_command(input logic [2:0] cmd, input logic signed [31:0] word);
        int gap;
        gap = (!tx_calm && $urandom_range(0, 99) < 35) ? idle_length() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{cmd: cmd, value: word};
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // Stop sending until every predicted result has come back
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    // Receiver: random stalls with occasional long stretches always ready
    always @(negedge clk)
    begin
        if (calm_left > 0)
        begin
            calm_left--;
            out_ready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if ($urandom_range(0, 199) == 0)
        begin
            calm_left = $urandom_range(30, 120);
            out_ready <= 1'b1;
        end
        else if ($urandom_range(0, 99) < 25)
        begin
            stall_left = idle_length() - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Stimulus and verdict
    initial
    begin : stimulus
        int lean;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty deque: report, then pops that must be rejected
        send_command(CMD_REPORT, 32'sh1234_5678);
        send_command(CMD_POP_FRONT, '0);
        send_command(CMD_POP_REAR, '0);
        // extremes of the word, then pop down to empty
        send_command(CMD_PUSH_FRONT, 32'sh7fff_ffff);
        send_command(CMD_PUSH_REAR, 32'sh8000_0000);
        send_command(CMD_POP_REAR, '0);
        send_command(CMD_POP_FRONT, '0);
        // fill to full, with the front index wrapping past slot zero
        send_command(CMD_PUSH_REAR, EMPTY_WORD);
        send_command(CMD_PUSH_FRONT, '0);
        for (int k = 0; k < DEPTH - 2; k++)
            send_command((k % 2) ? CMD_PUSH_REAR : CMD_PUSH_FRONT, $urandom);
        // pushes into a full deque are rejected
        send_command(CMD_PUSH_FRONT, $urandom);
        send_command(CMD_PUSH_REAR, $urandom);
        // spare codes behave as a report
        for (int c = CMD_REPORT + 1; c <= CMD_LAST; c++)
            send_command(3'(c), $urandom);
        send_command(CMD_POP_FRONT, $urandom);
        send_command(CMD_POP_REAR, $urandom);
        hold_until_drained();

        // random traffic in segments of varying push/pop balance
        lean = 2;
        for (int n = 0; n < RANDOM_CMDS; n++)
        begin
            if (n % 64 == 0)
            begin
                lean    = $urandom_range(0, 2);
                tx_calm = ($urandom_range(0, 4) == 0);
            end
            if (n % 400 == 399)
                hold_until_drained();
            send_command(pick_command(lean), pick_word());
        end

        // drain, then give stray results a chance to show up
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
